### sv/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// types, register indexes and constants shared by the button debounce blocks
// ----------------------------------------------------------------------------
package bdp_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int CFG_WIDTH          = 16;
    localparam int HOLD_WIDTH         = 32;
    localparam int S_TDATA_WIDTH      = 8;
    localparam int M_TDATA_WIDTH      = 40;
    localparam int QUEUE_WIDTH        = 4;

    localparam logic [CFG_WIDTH-1:0]   DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0]   WINDOW_RESET   = 16'd300;
    localparam logic [QUEUE_WIDTH-1:0] QUEUE_MAX      = 4'd15;

    typedef enum logic [0:0] {
        REG_DEBOUNCE = 1'b0,
        REG_WINDOW   = 1'b1
    } reg_index_t;

    typedef logic [QUEUE_WIDTH-1:0] queue_t;

    typedef struct packed {
        logic pin_level;
        logic clear;
    } tick_t;

    typedef struct packed {
        logic [HOLD_WIDTH-1:0] hold_ms;
        logic                  held;
        logic                  release_event;
        logic                  double_press_event;
        logic                  press_event;
    } result_t;

endpackage

### sv/bdp_in_stage.sv
// ----------------------------------------------------------------------------
// bdp_in_stage
// input register for one tick request, refilled whenever it moves on
// ----------------------------------------------------------------------------
module bdp_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdp_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // [0] pin_level, [1] clear
    input  logic                              advance,
    output logic                              valid,
    output bdp_pkg::tick_t                    tick
);
    import bdp_pkg::*;

    logic  valid_reg;
    tick_t tick_reg;

    assign s_tready = !valid_reg || advance;
    assign valid    = valid_reg;
    assign tick     = tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg.pin_level <= s_tdata[0];
            tick_reg.clear     <= s_tdata[1];
        end
    end

endmodule

### sv/bdp_engine.sv
// ----------------------------------------------------------------------------
// bdp_engine
// millisecond counter, debounce and double-press tracking state, result logic
// ----------------------------------------------------------------------------
module bdp_engine #(
    parameter int TIME_WIDTH = bdp_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  bdp_pkg::reg_index_t           cfg_addr,
    input  logic [bdp_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                          step,
    input  bdp_pkg::tick_t                tick,
    output bdp_pkg::result_t              result
);
    import bdp_pkg::*;

    logic [CFG_WIDTH-1:0]  debounce_reg;
    logic [CFG_WIDTH-1:0]  window_reg;

    logic [TIME_WIDTH-1:0] now_reg,         now_next;
    logic [TIME_WIDTH-1:0] last_edge_reg,   last_edge_next;
    logic [TIME_WIDTH-1:0] last_press_reg,  last_press_next;
    logic [TIME_WIDTH-1:0] press_start_reg, press_start_next;
    logic                  press_valid_reg, press_valid_next;
    queue_t                queue_reg,       queue_next;
    logic                  awaiting_reg,    awaiting_next;

    logic [TIME_WIDTH-1:0] debounce_ext;
    logic [TIME_WIDTH-1:0] window_ext;
    logic [TIME_WIDTH-1:0] since_edge;
    logic [TIME_WIDTH-1:0] since_press_old;
    logic [TIME_WIDTH-1:0] since_press_new;
    logic [TIME_WIDTH-1:0] since_start;
    logic                  settled;

    assign debounce_ext = TIME_WIDTH'(debounce_reg);
    assign window_ext   = TIME_WIDTH'(window_reg);
    assign now_next     = now_reg + TIME_WIDTH'(1);
    assign since_edge      = now_next - last_edge_reg;
    assign since_press_old = now_next - last_press_reg;
    assign since_press_new = now_next - last_press_next;
    assign since_start     = now_next - press_start_next;
    assign settled         = since_edge > debounce_ext;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            window_reg   <= WINDOW_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                REG_WINDOW:   window_reg   <= cfg_wdata;
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // tick logic
    always_comb begin
        last_edge_next   = last_edge_reg;
        last_press_next  = last_press_reg;
        press_start_next = press_start_reg;
        press_valid_next = press_valid_reg;
        queue_next       = queue_reg;
        awaiting_next    = awaiting_reg;
        result           = '0;

        if (tick.clear) begin
            last_edge_next   = '0;
            last_press_next  = '0;
            press_start_next = '0;
            press_valid_next = 1'b0;
            queue_next       = '0;
            awaiting_next    = 1'b0;
        end else begin
            if (tick.pin_level) begin
                if (awaiting_reg && settled) begin
                    awaiting_next        = 1'b0;
                    result.release_event = 1'b1;
                    last_edge_next       = now_next;
                end
            end else if (!awaiting_reg && settled) begin
                if (press_valid_reg && (since_press_old < window_ext)) begin
                    result.double_press_event = 1'b1;
                    queue_next                = '0;
                end else if (queue_reg != QUEUE_MAX) begin
                    queue_next = queue_reg + queue_t'(1);
                end
                last_press_next  = now_next;
                press_valid_next = 1'b1;
                press_start_next = now_next;
                awaiting_next    = 1'b1;
                last_edge_next   = now_next;
            end

            if ((queue_next != '0) && (since_press_new >= window_ext)) begin
                queue_next         = queue_next - queue_t'(1);
                result.press_event = 1'b1;
            end

            result.held = awaiting_next;
            if (awaiting_next) begin
                result.hold_ms = HOLD_WIDTH'(since_start);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg         <= '0;
            last_edge_reg   <= '0;
            last_press_reg  <= '0;
            press_start_reg <= '0;
            press_valid_reg <= 1'b0;
            queue_reg       <= '0;
            awaiting_reg    <= 1'b0;
        end else if (step) begin
            now_reg         <= now_next;
            last_edge_reg   <= last_edge_next;
            last_press_reg  <= last_press_next;
            press_start_reg <= press_start_next;
            press_valid_reg <= press_valid_next;
            queue_reg       <= queue_next;
            awaiting_reg    <= awaiting_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_single_or_double : assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !(result.press_event && result.double_press_event))
        else $error("single and double press in the same tick");

    a_release_needs_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.release_event) |-> awaiting_reg)
        else $error("release without a held press");

    a_clear_empties : assert property (@(posedge aclk) disable iff (!aresetn)
        (step && tick.clear) |=> (queue_reg == '0) && !awaiting_reg && !press_valid_reg)
        else $error("clear left tracking state behind");

    a_counter_steps : assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> now_reg == $past(now_reg) + TIME_WIDTH'(1))
        else $error("millisecond counter did not advance by one");

    a_hold_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !awaiting_next) |-> (result.hold_ms == '0))
        else $error("hold time reported while not held");
`endif

endmodule

### sv/bdp_out_stage.sv
// ----------------------------------------------------------------------------
// bdp_out_stage
// result register towards the master side, frees up when the request is taken
// ----------------------------------------------------------------------------
module bdp_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  bdp_pkg::result_t                  result,
    output logic                              advance,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] press_event, [1] double_press_event, [2] release_event, [3] held,
    // [35:4] hold_ms, [39:36] zero
    output logic [bdp_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import bdp_pkg::*;

    localparam int PAD_WIDTH = M_TDATA_WIDTH - HOLD_WIDTH - 4;

    logic    valid_reg;
    result_t result_reg;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_WIDTH{1'b0}}, result_reg.hold_ms, result_reg.held,
                       result_reg.release_event, result_reg.double_press_event,
                       result_reg.press_event};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

### sv/button_debounce_double_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_double_press_core
// pushbutton debounce with single, double press, release and hold reporting
// ----------------------------------------------------------------------------
// usage: send one request on the s_ channel per millisecond tick, carrying
// the sampled pin level (1 released, 0 pressed) and a clear flag. every tick
// gives exactly one result request on the m_ channel with the press, double
// press and release pulses, the held flag and the hold time in ms.
// flow: an accepted tick waits in the input register, is then loaded into the
// result register and is shown on m_tvalid; throughput is one tick per cycle
// while m_tready stays high, set by the single pass of tracking logic between
// the input and result registers.
// stall: while m_tready is low the result register holds its request and the
// input register takes one more tick; s_tready then drops until m_tready
// returns, and no request is lost or repeated.
// reset: aresetn low empties both registers, clears the ms counter and all tracking
// state, and restores debounce_ms = 50 and double_press_window_ms = 300.
// configuration: write cfg_wdata to register cfg_addr (0 debounce, 1 window)
// with cfg_we high, only while no tick is in flight.
// ----------------------------------------------------------------------------
module button_debounce_double_press_core #(
    parameter int TIME_WIDTH = bdp_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  bdp_pkg::reg_index_t               cfg_addr,
    input  logic [bdp_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdp_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // [0] pin_level, [1] clear
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] press_event, [1] double_press_event, [2] release_event, [3] held,
    // [35:4] hold_ms, [39:36] zero
    output logic [bdp_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
    import bdp_pkg::*;

    logic    in_valid;
    tick_t   tick;
    logic    advance;
    logic    step;
    result_t result;

    assign step = in_valid && advance;

    bdp_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .valid    (in_valid),
        .tick     (tick)
    );

    bdp_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .tick      (tick),
        .result    (result)
    );

    bdp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
